/* rtl/core/lgrs_pkg.sv */
// Shared types, constants and the Life stencil function for the row stencil core.
package lgrs_pkg;

    localparam int ROW_W       = 64;
    localparam int COL_W       = 7;
    localparam int CNT_W       = 4;
    localparam int MAX_COLUMNS = 64;

    localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
    localparam logic [CNT_W-1:0] STAY_COUNT  = CNT_W'(2);

    localparam logic [COL_W-1:0] COLUMNS_RESET = COL_W'(10);

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             last_row;
    } in_word_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_row_cells;
        logic             grid_end;
        logic             run_last;
    } out_word_t;

    // What the back end must produce for one accepted row.
    typedef enum logic [1:0] {
        JOB_MID  = 2'd0,   // one interior row
        JOB_SOLO = 2'd1,   // one-row grid
        JOB_PAIR = 2'd2    // last row: the row above it, then its own
    } job_kind_t;

    typedef struct packed {
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] here;
        logic [ROW_W-1:0] below;
        job_kind_t        kind;
    } cmd_t;

    // Bit k set for every column below n; saturates at MAX_COLUMNS.
    function automatic logic [ROW_W-1:0] col_mask(input logic [COL_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int k = 0; k < ROW_W; k++)
        begin
            m[k] = (k < MAX_COLUMNS) && (COL_W'(k) < n);
        end
        return m;
    endfunction

    // B3/S23 on one row, dead border, no wrap.
    function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] above,
                                                  input logic [ROW_W-1:0] here,
                                                  input logic [ROW_W-1:0] below);
        logic [ROW_W+1:0] a_p;
        logic [ROW_W+1:0] h_p;
        logic [ROW_W+1:0] b_p;
        logic [CNT_W-1:0] cnt;
        logic [ROW_W-1:0] res;
        a_p = {1'b0, above, 1'b0};
        h_p = {1'b0, here, 1'b0};
        b_p = {1'b0, below, 1'b0};
        for (int k = 0; k < ROW_W; k++)
        begin
            cnt = CNT_W'(a_p[k]) + CNT_W'(a_p[k+1]) + CNT_W'(a_p[k+2])
                + CNT_W'(h_p[k]) + CNT_W'(h_p[k+2])
                + CNT_W'(b_p[k]) + CNT_W'(b_p[k+1]) + CNT_W'(b_p[k+2]);
            res[k] = (cnt == BIRTH_COUNT) || (here[k] && (cnt == STAY_COUNT));
        end
        return res;
    endfunction

endpackage

/* rtl/core/life_generation_row_stencil_core.sv */
// Top level of the Life (B3/S23) row stencil core: front end, job queue, back end.
//
// One generation of Conway's Life, streamed a row at a time: each word pushed
// is one grid row (bit k = column k alive) plus a last-row flag. Cells outside
// the grid are dead and nothing wraps. The first row of a grid is only held;
// every later row pops out the next-generation row above it, and the last row
// also yields its own row, so the last row of an N-row grid gives two result
// words and a one-row grid gives one. grid_end flags the final row of the new
// generation; run_last flags the last result word caused by an input word.
// columns_in_use (reset 10, values above 64 act as 64) kills columns at and
// above it on input and zeroes them on output; write it only while the core
// is drained. Rate: one input word per clock while the job queue has room,
// limited by the single stencil unit in the back end, which produces one result
// word per clock while the result queue has room; a last row therefore occupies
// the back end for two result words. A pushed word reaches the result ports
// through the job queue register, then the result queue register. The front
// end and back end are split by a two-entry job queue, and results wait in a
// two-entry queue, so either side can stall without stopping the other at once.
module life_generation_row_stencil_core
    import lgrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  in_word_t         item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output out_word_t        result,
    input  logic             cfg_we,
    input  logic [COL_W-1:0] cfg_data
);

    logic [COL_W-1:0] columns_in_use_reg;
    logic [COL_W-1:0] columns_in_use_next;
    logic [ROW_W-1:0] mask;

    // Front-to-queue and queue-to-back handshakes.
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_head;

    // Configuration register: plain write, no read-back.
    assign columns_in_use_next = cfg_we ? cfg_data : columns_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_in_use_reg <= COLUMNS_RESET;
        end
        else
        begin
            columns_in_use_reg <= columns_in_use_next;
        end
    end

    // Both ends' column mask; user keeps it stable with words in flight; no check.
    assign mask = col_mask(columns_in_use_reg);

    lgrs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .mask     (mask),
        .cmd_full (cmd_full),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    lgrs_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .head  (cmd_head)
    );

    lgrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mask      (mask),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // The front end never issues a job into a full queue.
    a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_push && cmd_full))
        else $error("job issued into full queue");

    // A shown result carries no live cell outside the active columns.
    a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.next_row_cells & ~mask) == '0))
        else $error("result has cells beyond columns_in_use");

    // The final row of a generation always closes the run of its input word.
    a_grid_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.grid_end) |-> result.run_last)
        else $error("grid_end without run_last");

endmodule

/* rtl/core/lgrs_front.sv */
// Front end: accepts rows, keeps the two previous rows and issues stencil jobs.
module lgrs_front
    import lgrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  in_word_t         item,
    input  logic [ROW_W-1:0] mask,
    input  logic             cmd_full,
    output logic             full,
    output logic             cmd_push,
    output cmd_t             cmd
);

    logic [ROW_W-1:0] upper_reg;
    logic [ROW_W-1:0] upper_next;
    logic [ROW_W-1:0] middle_reg;
    logic [ROW_W-1:0] middle_next;
    logic             held_reg;
    logic             held_next;
    logic             accept;
    logic [ROW_W-1:0] row;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign row    = item.row_cells & mask;

    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        cmd_push    = 1'b0;
        cmd.above   = upper_reg & mask;
        cmd.here    = middle_reg & mask;
        cmd.below   = row;
        cmd.kind    = JOB_MID;
        if (accept)
        begin
            if (!held_reg)
            begin
                if (item.last_row)
                begin
                    cmd_push  = 1'b1;
                    cmd.above = '0;
                    cmd.here  = row;
                    cmd.below = '0;
                    cmd.kind  = JOB_SOLO;
                end
                else
                begin
                    upper_next  = '0;
                    middle_next = row;
                    held_next   = 1'b1;
                end
            end
            else
            begin
                cmd_push = 1'b1;
                if (item.last_row)
                begin
                    cmd.kind    = JOB_PAIR;
                    upper_next  = '0;
                    middle_next = '0;
                    held_next   = 1'b0;
                end
                else
                begin
                    upper_next  = middle_reg;
                    middle_next = row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= '0;
            middle_reg <= '0;
            held_reg   <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
            held_reg   <= held_next;
        end
    end

endmodule

/* rtl/core/lgrs_cmd_queue.sv */
// Two-entry job queue between the front and back ends.
module lgrs_cmd_queue
    import lgrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* rtl/core/lgrs_back.sv */
// Back end: stencil evaluation per job and the two-entry result queue.
module lgrs_back
    import lgrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ROW_W-1:0] mask,
    input  logic             cmd_empty,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic             pop,
    output logic             empty,
    output out_word_t        result
);

    out_word_t        oq_reg [2];
    logic             owr_ptr_reg;
    logic             owr_ptr_next;
    logic             ord_ptr_reg;
    logic             ord_ptr_next;
    logic [1:0]       ocount_reg;
    logic [1:0]       ocount_next;
    logic             second_reg;
    logic             second_next;
    logic             ofull;
    logic             fire;
    logic             do_pop;
    logic [ROW_W-1:0] s_above;
    logic [ROW_W-1:0] s_here;
    logic [ROW_W-1:0] s_below;
    out_word_t        res;

    assign ofull  = (ocount_reg == 2'd2);
    assign empty  = (ocount_reg == 2'd0);
    assign result = oq_reg[ord_ptr_reg];
    assign fire   = !cmd_empty && !ofull;
    assign do_pop = pop && !empty;

    // Second half of a pair shifts the window down one row.
    always_comb
    begin
        s_above = second_reg ? cmd.here  : cmd.above;
        s_here  = second_reg ? cmd.below : cmd.here;
        s_below = second_reg ? '0        : cmd.below;
        res.next_row_cells = life_row(s_above, s_here, s_below) & mask;
        unique case (cmd.kind)
            JOB_MID:
            begin
                res.grid_end = 1'b0;
                res.run_last = 1'b1;
            end
            JOB_SOLO:
            begin
                res.grid_end = 1'b1;
                res.run_last = 1'b1;
            end
            JOB_PAIR:
            begin
                res.grid_end = second_reg;
                res.run_last = second_reg;
            end
            default:
            begin
                res.grid_end = 1'b1;
                res.run_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = fire && ((cmd.kind != JOB_PAIR) || second_reg);
        second_next = second_reg;
        if (fire)
        begin
            second_next = (cmd.kind == JOB_PAIR) && !second_reg;
        end
        owr_ptr_next = owr_ptr_reg ^ fire;
        ord_ptr_next = ord_ptr_reg ^ do_pop;
        ocount_next  = ocount_reg + 2'(fire) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg  <= 1'b0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            second_reg  <= second_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            oq_reg[owr_ptr_reg] <= res;
        end
    end

endmodule
